### design/sfls_pkg.sv
// ----------------------------------------------------------------------------
// sfls_pkg
// Shared codes, widths and control types for the stereo FIR / level block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfls_pkg;

    // request kinds carried on tuser
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_COEFF  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_EN = 2'd0;
    localparam logic [1:0] CFG_LEVEL_L   = 2'd1;
    localparam logic [1:0] CFG_LEVEL_R   = 2'd2;

    localparam int COEFF_W     = 32;
    localparam int LEVEL_W     = 16;
    localparam int ACC_W       = 64;
    localparam int CIDX_W      = 7;
    localparam int FIR_SHIFT   = 31;
    localparam int LEVEL_SHIFT = 15;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'h8000;

    // sequencer to datapath strobes
    typedef struct packed {
        logic load_sample;   // take input sample as scaling source
        logic load_zero;     // clear request: source is zero
        logic acc_clear;     // start of a new request
        logic mul_en;        // memory read data valid, form product
        logic acc_en;        // product valid, accumulate
        logic fir_norm;      // accumulator final, normalize into source
        logic scale_en;      // apply level
    } sfls_ctrl_t;

endpackage

`default_nettype wire

### design/sfls_ram.sv
// ----------------------------------------------------------------------------
// sfls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/sfls_mac.sv
// ----------------------------------------------------------------------------
// sfls_mac
// One channel: multiply-accumulate over taps, Q1.31 normalize, level scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module sfls_mac
    import sfls_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  sfls_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] hist_data,
    input  logic signed [COEFF_W-1:0]     tap_data,
    input  logic        [LEVEL_W-1:0]     level,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int PW = SAMPLE_BITS + LEVEL_W + 1;
    localparam logic signed [ACC_W-1:0] ACC_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI - 64'sd1;
    localparam logic signed [PW-1:0] P_HI = PW'(ACC_HI);
    localparam logic signed [PW-1:0] P_LO = PW'(ACC_LO);

    logic signed [SAMPLE_BITS+COEFF_W-1:0] prod_w;
    logic signed [ACC_W-1:0]               prod_reg;
    logic signed [ACC_W-1:0]               acc_reg;
    logic signed [ACC_W-1:0]               fir_sh;
    logic signed [SAMPLE_BITS-1:0]         fir_sat;
    logic signed [SAMPLE_BITS-1:0]         src_reg;
    logic        [LEVEL_W-1:0]             level_c;
    logic signed [LEVEL_W:0]               level_s;
    logic signed [PW-1:0]                  scaled_w;
    logic signed [PW-1:0]                  scaled_reg;
    logic signed [PW-1:0]                  scaled_sh;

    assign prod_w = hist_data * tap_data;

    assign fir_sh  = acc_reg >>> FIR_SHIFT;
    assign fir_sat = (fir_sh > ACC_HI) ? SAMPLE_BITS'(ACC_HI) :
                     (fir_sh < ACC_LO) ? SAMPLE_BITS'(ACC_LO) :
                     fir_sh[SAMPLE_BITS-1:0];

    // gain above unity is held at unity
    assign level_c  = (level > LEVEL_MAX) ? LEVEL_MAX : level;
    assign level_s  = $signed({1'b0, level_c});
    assign scaled_w = src_reg * level_s;

    assign scaled_sh = scaled_reg >>> LEVEL_SHIFT;
    assign result    = (scaled_sh > P_HI) ? SAMPLE_BITS'(P_HI) :
                       (scaled_sh < P_LO) ? SAMPLE_BITS'(P_LO) :
                       scaled_sh[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= ACC_W'(prod_w);
        end

        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end

        if (ctrl.load_zero)
        begin
            src_reg <= '0;
        end
        else if (ctrl.load_sample)
        begin
            src_reg <= sample;
        end
        else if (ctrl.fir_norm)
        begin
            src_reg <= fir_sat;
        end

        if (ctrl.scale_en)
        begin
            scaled_reg <= scaled_w;
        end
    end

endmodule

`default_nettype wire

### design/stereo_fir_with_level_scaling_top.sv
// ----------------------------------------------------------------------------
// stereo_fir_with_level_scaling_top
// Stereo FIR filter with per-channel level scaling, memory-based delay lines.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per handshake. tuser is the kind: sample tick, clear
//   delay lines, or coefficient write. A sample or clear request yields one
//   result on m_axis; a coefficient write (or unused kind) yields nothing.
//   cfg_we/cfg_index/cfg_data write filter_enable and both levels; write
//   only while no request is in flight.
// Sequencing:
//   Filtered sample: the single MAC per channel reads one tap and one history
//   word per cycle from the memories, then drains the product pipeline,
//   normalizes, scales by the level and loads the output register.
//   Bypassed sample or clear: scale, then output. Coefficient write: no result.
//   One request is in flight at a time; s_axis_tready is high while idle.
// Stall:
//   Results sit in an output register; a new request is accepted while it
//   waits, and the sequencer holds its finished result until that register
//   frees up.
// Reset:
//   Config clears to zero. History and coefficients read as zero through
//   per-entry valid flags cleared by reset, so there is no clearing pass;
//   a clear request drops all the history flags.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_fir_with_level_scaling_top
    import sfls_pkg::*;
#(
    parameter int TAP_COUNT   = 51,
    parameter int SAMPLE_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // audio_left, audio_right, coeff_index, coeff_value, zero pad
    input  logic [((2*SAMPLE_BITS+CIDX_W+COEFF_W+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]        s_axis_tuser,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_left, out_right, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,

    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [LEVEL_W-1:0] cfg_data
);

    localparam int AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int OUT_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int IX_W  = 9;
    localparam int CI_LO = 2*SAMPLE_BITS;
    localparam int CV_LO = CI_LO + CIDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_FINAL
    } state_t;

    state_t state_reg;

    // configuration
    logic               filter_en_reg;
    logic [LEVEL_W-1:0] level_l_reg;
    logic [LEVEL_W-1:0] level_r_reg;

    // request fields
    logic                   accept;
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] audio_l;
    logic [SAMPLE_BITS-1:0] audio_r;
    logic [CIDX_W-1:0]      cidx;
    logic [COEFF_W-1:0]     cval;

    // delay line pointer, tap counter, read pipeline
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   wp_inc;
    logic [AW-1:0]   rd_idx_reg;
    logic [AW-1:0]   hist_raddr;
    logic            rd_last;
    logic            s1_vld_reg;
    logic            s2_vld_reg;

    // entry valid flags: an entry not yet written reads as zero
    logic [TAP_COUNT-1:0] hist_vld_reg;
    logic [TAP_COUNT-1:0] tap_l_vld_reg;
    logic [TAP_COUNT-1:0] tap_r_vld_reg;
    logic                 hv_q_reg;
    logic                 tlv_q_reg;
    logic                 trv_q_reg;

    // coefficient address decode
    logic [IX_W-1:0] cidx_w;
    logic            left_hit;
    logic            right_hit;
    logic [AW-1:0]   tap_l_waddr;
    logic [AW-1:0]   tap_r_waddr;

    // memory ports
    logic                     hist_we;
    logic [2*SAMPLE_BITS-1:0] hist_rdata;
    logic [COEFF_W-1:0]       tap_l_rdata;
    logic [COEFF_W-1:0]       tap_r_rdata;

    // datapath
    sfls_ctrl_t             ctrl;
    logic [SAMPLE_BITS-1:0] hist_l;
    logic [SAMPLE_BITS-1:0] hist_r;
    logic [COEFF_W-1:0]     tap_l;
    logic [COEFF_W-1:0]     tap_r;
    logic [SAMPLE_BITS-1:0] res_l;
    logic [SAMPLE_BITS-1:0] res_r;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = s_axis_tuser;
    assign audio_l       = s_axis_tdata[SAMPLE_BITS-1:0];
    assign audio_r       = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign cidx          = s_axis_tdata[CV_LO-1:CI_LO];
    assign cval          = s_axis_tdata[CV_LO+COEFF_W-1:CV_LO];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // finished result moves into the output register once it is free
    assign out_load = (state_reg == ST_FINAL) && (!out_valid_reg || m_axis_tready);

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg <= 1'b0;
            level_l_reg   <= '0;
            level_r_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_EN: filter_en_reg <= cfg_data[0];
                CFG_LEVEL_L:   level_l_reg   <= cfg_data;
                CFG_LEVEL_R:   level_r_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // address generation
    // ------------------------------------------------------------------
    // circular delay line: wp_reg is the newest entry, tap i sits i behind
    assign wp_inc  = (wp_reg == AW'(TAP_COUNT - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_last = (rd_idx_reg == AW'(TAP_COUNT - 1));

    always_comb
    begin
        if (wp_reg >= rd_idx_reg)
        begin
            hist_raddr = wp_reg - rd_idx_reg;
        end
        else
        begin
            hist_raddr = AW'({1'b0, wp_reg} + (AW+1)'(TAP_COUNT) - {1'b0, rd_idx_reg});
        end
    end

    // slots below TAP_COUNT are left taps, the next TAP_COUNT are right taps
    assign cidx_w      = IX_W'(cidx);
    assign left_hit    = (cidx_w < IX_W'(TAP_COUNT));
    assign right_hit   = !left_hit && (cidx_w < IX_W'(2*TAP_COUNT));
    assign tap_l_waddr = AW'(cidx_w);
    assign tap_r_waddr = AW'(cidx_w - IX_W'(TAP_COUNT));

    assign hist_we = accept && (mode == MODE_SAMPLE);

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    sfls_ram #(
        .WIDTH (2*SAMPLE_BITS),
        .DEPTH (TAP_COUNT)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (wp_inc),
        .wdata ({audio_r, audio_l}),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    sfls_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (TAP_COUNT)
    ) u_tap_l_ram (
        .clk   (clk),
        .we    (accept && (mode == MODE_COEFF) && left_hit),
        .waddr (tap_l_waddr),
        .wdata (cval),
        .raddr (rd_idx_reg),
        .rdata (tap_l_rdata)
    );

    sfls_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (TAP_COUNT)
    ) u_tap_r_ram (
        .clk   (clk),
        .we    (accept && (mode == MODE_COEFF) && right_hit),
        .waddr (tap_r_waddr),
        .wdata (cval),
        .raddr (rd_idx_reg),
        .rdata (tap_r_rdata)
    );

    // unwritten entries read as zero
    assign hist_l = hv_q_reg  ? hist_rdata[SAMPLE_BITS-1:0] : '0;
    assign hist_r = hv_q_reg  ? hist_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign tap_l  = tlv_q_reg ? tap_l_rdata : '0;
    assign tap_r  = trv_q_reg ? tap_r_rdata : '0;

    // ------------------------------------------------------------------
    // datapath strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.load_sample = accept && (mode == MODE_SAMPLE);
        ctrl.load_zero   = accept && (mode == MODE_CLEAR);
        ctrl.acc_clear   = accept;
        ctrl.mul_en      = s1_vld_reg;
        ctrl.acc_en      = s2_vld_reg;
        ctrl.fir_norm    = (state_reg == ST_DRAIN) && !s1_vld_reg && !s2_vld_reg;
        ctrl.scale_en    = (state_reg == ST_SCALE);
    end

    sfls_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac_l (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (audio_l),
        .hist_data (hist_l),
        .tap_data  (tap_l),
        .level     (level_l_reg),
        .result    (res_l)
    );

    sfls_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac_r (
        .clk       (clk),
        .ctrl      (ctrl),
        .sample    (audio_r),
        .hist_data (hist_r),
        .tap_data  (tap_r),
        .level     (level_r_reg),
        .result    (res_r)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rd_idx_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            hist_vld_reg  <= '0;
            tap_l_vld_reg <= '0;
            tap_r_vld_reg <= '0;
            hv_q_reg      <= 1'b0;
            tlv_q_reg     <= 1'b0;
            trv_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            s1_vld_reg <= (state_reg == ST_MAC);
            s2_vld_reg <= s1_vld_reg;
            hv_q_reg   <= hist_vld_reg[hist_raddr];
            tlv_q_reg  <= tap_l_vld_reg[rd_idx_reg];
            trv_q_reg  <= tap_r_vld_reg[rd_idx_reg];

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= OUT_W'({res_r, res_l});
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (mode)
                            MODE_SAMPLE:
                            begin
                                wp_reg               <= wp_inc;
                                hist_vld_reg[wp_inc] <= 1'b1;
                                rd_idx_reg           <= '0;
                                state_reg <= filter_en_reg ? ST_MAC : ST_SCALE;
                            end
                            MODE_CLEAR:
                            begin
                                hist_vld_reg <= '0;
                                state_reg    <= ST_SCALE;
                            end
                            MODE_COEFF:
                            begin
                                if (left_hit)
                                begin
                                    tap_l_vld_reg[tap_l_waddr] <= 1'b1;
                                end
                                else if (right_hit)
                                begin
                                    tap_r_vld_reg[tap_r_waddr] <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAC:
                begin
                    if (rd_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    // wait for the last product to land in the accumulator
                    if (!s1_vld_reg && !s2_vld_reg)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    state_reg <= ST_FINAL;
                end
                ST_FINAL:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/sfls_checker.sv
// ----------------------------------------------------------------------------
// sfls_checker
// Port-level checks for the stereo FIR / level block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfls_checker
    import sfls_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [((2*SAMPLE_BITS+CIDX_W+COEFF_W+7)/8)*8-1:0] s_axis_tdata,
    input logic [1:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic              cfg_we,
    input logic [1:0]        cfg_index,
    input logic [LEVEL_W-1:0] cfg_data
);

    // held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a sample request keeps the block busy
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SAMPLE)
        |=> !s_axis_tready)
        else $error("new request taken during sample processing");

    // coefficient writes finish in place
    a_coeff_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_COEFF)
        |=> s_axis_tready)
        else $error("coefficient write stalled input");

    // clear with an empty output gives a zero result after the scale and final states
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_CLEAR) && !m_axis_tvalid
        |-> ##3 (m_axis_tvalid && (m_axis_tdata == '0)))
        else $error("clear result missing or nonzero");

    // a result only appears once the input has been closed
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

endmodule

bind stereo_fir_with_level_scaling_top sfls_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sfls_checker (.*);

`default_nettype wire
